// ===== src/hgm_pkg.sv =====
// Package for the heightmap grid mesher: widths, register codes, item types
// and the 48-bit saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hgm_pkg;

  localparam int unsigned MaxColumns = 4096;
  localparam int unsigned MaxRows    = 4096;

  localparam int unsigned ColW  = $clog2(MaxColumns);
  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned WidW  = ColW + 1;
  localparam int unsigned IdxW  = 24;
  localparam int unsigned RegW  = 32;
  localparam int unsigned PosW  = 48;
  localparam int unsigned AddrW = 3;
  localparam int unsigned SumW  = PosW + 2;

  localparam logic [ColW-1:0] ColLast = ColW'(MaxColumns - 1);
  localparam logic [RowW-1:0] RowLast = RowW'(MaxRows - 1);

  // register indexes on the configuration port
  localparam logic [AddrW-1:0] RegXOrigin    = 3'd0;
  localparam logic [AddrW-1:0] RegXPerColumn = 3'd1;
  localparam logic [AddrW-1:0] RegXPerRow    = 3'd2;
  localparam logic [AddrW-1:0] RegYOrigin    = 3'd3;
  localparam logic [AddrW-1:0] RegYPerColumn = 3'd4;
  localparam logic [AddrW-1:0] RegYPerRow    = 3'd5;
  localparam logic [AddrW-1:0] RegZGain      = 3'd6;
  localparam logic [AddrW-1:0] RegZOffset    = 3'd7;

  typedef struct packed {
    logic signed [RegW-1:0] x_origin;
    logic signed [RegW-1:0] x_per_column;
    logic signed [RegW-1:0] x_per_row;
    logic signed [RegW-1:0] y_origin;
    logic signed [RegW-1:0] y_per_column;
    logic signed [RegW-1:0] y_per_row;
    logic signed [RegW-1:0] z_gain;
    logic signed [RegW-1:0] z_offset;
  } hgm_cfg_t;

  // one sample after the index stage
  typedef struct packed {
    logic signed [RegW-1:0] height;
    logic [ColW-1:0]        col;
    logic [RowW-1:0]        row;
    logic [IdxW-1:0]        vertex_index;
    logic                   cell_done;
    logic [IdxW-1:0]        first_tri_a;
    logic [IdxW-1:0]        first_tri_b;
    logic [IdxW-1:0]        first_tri_c;
    logic [IdxW-1:0]        second_tri_a;
    logic [IdxW-1:0]        second_tri_b;
    logic [IdxW-1:0]        second_tri_c;
  } hgm_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] x_position;
    logic signed [PosW-1:0] y_position;
    logic signed [PosW-1:0] z_position;
    logic [IdxW-1:0]        vertex_index;
    logic                   cell_done;
    logic [IdxW-1:0]        first_tri_a;
    logic [IdxW-1:0]        first_tri_b;
    logic [IdxW-1:0]        first_tri_c;
    logic [IdxW-1:0]        second_tri_a;
    logic [IdxW-1:0]        second_tri_b;
    logic [IdxW-1:0]        second_tri_c;
  } hgm_result_t;

  function automatic logic signed [PosW-1:0] sat48(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'({1'b0, {(PosW-1){1'b1}}});
    lo = -hi - SumW'(1);
    if (v > hi) begin
      sat48 = hi[PosW-1:0];
    end else if (v < lo) begin
      sat48 = lo[PosW-1:0];
    end else begin
      sat48 = v[PosW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/hgm_cfg.sv =====
// Configuration register file of the heightmap grid mesher.
// Depends on hgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hgm_cfg
  import hgm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [AddrW-1:0] cfg_addr_i,
  input  wire logic [RegW-1:0]  cfg_data_i,
  output hgm_cfg_t              cfg_o
);

  hgm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        RegXOrigin:    cfg_d.x_origin     = cfg_data_i;
        RegXPerColumn: cfg_d.x_per_column = cfg_data_i;
        RegXPerRow:    cfg_d.x_per_row    = cfg_data_i;
        RegYOrigin:    cfg_d.y_origin     = cfg_data_i;
        RegYPerColumn: cfg_d.y_per_column = cfg_data_i;
        RegYPerRow:    cfg_d.y_per_row    = cfg_data_i;
        RegZGain:      cfg_d.z_gain       = cfg_data_i;
        RegZOffset:    cfg_d.z_offset     = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin     <= '0;
      cfg_q.x_per_column <= RegW'(65536);
      cfg_q.x_per_row    <= '0;
      cfg_q.y_origin     <= '0;
      cfg_q.y_per_column <= '0;
      cfg_q.y_per_row    <= RegW'(65536);
      cfg_q.z_gain       <= RegW'(65536);
      cfg_q.z_offset     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/hgm_index.sv =====
// Grid position counters and cell triangle indices; registers each accepted
// sample with its column, row and indices. Depends on hgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hgm_index
  import hgm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [RegW-1:0]  height_i,
  input  wire logic             row_end_i,
  input  wire logic             grid_end_i,
  output hgm_item_t             item_o
);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [WidW-1:0] width_q, width_d;
  logic            known_q, known_d;
  logic [IdxW-1:0] vtx_q, vtx_d;
  hgm_item_t       item_q, item_d;

  logic            closes_cell;
  logic [IdxW-1:0] w_ext;
  logic [IdxW-1:0] ll;

  assign closes_cell = (row_q != '0) && (col_q != '0) && ({1'b0, col_q} < width_q);
  assign w_ext       = IdxW'(width_q);
  assign ll          = vtx_q - w_ext - IdxW'(1);

  always_comb begin
    item_d              = '0;
    item_d.height       = height_i;
    item_d.col          = col_q;
    item_d.row          = row_q;
    item_d.vertex_index = vtx_q;
    item_d.cell_done    = closes_cell;
    if (closes_cell) begin
      item_d.first_tri_a  = ll;
      item_d.first_tri_b  = vtx_q - w_ext;
      item_d.first_tri_c  = vtx_q;
      item_d.second_tri_a = ll;
      item_d.second_tri_b = vtx_q;
      item_d.second_tri_c = vtx_q - IdxW'(1);
    end
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    width_d = width_q;
    known_d = known_q;
    vtx_d   = vtx_q;
    if (accept_i) begin
      if (grid_end_i) begin
        col_d   = '0;
        row_d   = '0;
        width_d = '0;
        known_d = 1'b0;
        vtx_d   = '0;
      end else begin
        vtx_d = vtx_q + IdxW'(1);
        if (row_end_i) begin
          if (!known_q) begin
            width_d = {1'b0, col_q} + WidW'(1);
            known_d = 1'b1;
          end
          col_d = '0;
          if (row_q < RowLast) begin
            row_d = row_q + RowW'(1);
          end
        end else if (col_q < ColLast) begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      width_q <= '0;
      known_q <= 1'b0;
      vtx_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      width_q <= width_d;
      known_q <= known_d;
      vtx_q   <= vtx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// ===== src/hgm_arith.sv =====
// Position arithmetic: a product stage (affine terms and height gain), then
// a sum, floor and saturate stage into the result register. Depends on hgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hgm_arith
  import hgm_pkg::*;
(
  input  wire logic  clk_i,
  input  hgm_cfg_t   cfg_i,
  input  hgm_item_t  item_i,
  input  wire logic  prod_en_i,
  input  wire logic  sum_en_i,
  output hgm_result_t result_o
);

  localparam int unsigned CPW = ColW + 1 + RegW;
  localparam int unsigned RPW = RowW + 1 + RegW;
  localparam int unsigned ZPW = 2 * RegW;

  logic signed [CPW-1:0] xc_q, yc_q;
  logic signed [RPW-1:0] xr_q, yr_q;
  logic signed [ZPW-1:0] zp_q;
  hgm_item_t             item_q;
  hgm_result_t           res_q, res_d;

  logic signed [SumW-1:0] x_sum, y_sum, z_sum;
  logic signed [ZPW-1:0]  z_floor;

  // columns and rows are unsigned: a zero bit on top keeps them positive
  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      xc_q   <= $signed({1'b0, item_i.col}) * cfg_i.x_per_column;
      yc_q   <= $signed({1'b0, item_i.col}) * cfg_i.y_per_column;
      xr_q   <= $signed({1'b0, item_i.row}) * cfg_i.x_per_row;
      yr_q   <= $signed({1'b0, item_i.row}) * cfg_i.y_per_row;
      zp_q   <= item_i.height * cfg_i.z_gain;
      item_q <= item_i;
    end
  end

  // arithmetic shift rounds towards minus infinity
  assign z_floor = zp_q >>> 16;
  assign x_sum   = SumW'(cfg_i.x_origin) + SumW'(xc_q) + SumW'(xr_q);
  assign y_sum   = SumW'(cfg_i.y_origin) + SumW'(yc_q) + SumW'(yr_q);
  assign z_sum   = SumW'(z_floor) + SumW'(cfg_i.z_offset);

  always_comb begin
    res_d.x_position   = sat48(x_sum);
    res_d.y_position   = sat48(y_sum);
    res_d.z_position   = sat48(z_sum);
    res_d.vertex_index = item_q.vertex_index;
    res_d.cell_done    = item_q.cell_done;
    res_d.first_tri_a  = item_q.first_tri_a;
    res_d.first_tri_b  = item_q.first_tri_b;
    res_d.first_tri_c  = item_q.first_tri_c;
    res_d.second_tri_a = item_q.second_tri_a;
    res_d.second_tri_b = item_q.second_tri_b;
    res_d.second_tri_c = item_q.second_tri_c;
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== src/heightmap_grid_mesher.sv =====
// Heightmap grid mesher: turns row-major height samples into mesh vertices
// and cell triangles. Depends on hgm_pkg, hgm_cfg, hgm_index and hgm_arith.
//
// Each accepted sample yields one vertex transaction when the output side is
// ready, after an index stage, a product stage and a sum and saturate stage,
// each with its own valid bit and elastic handshake, so one sample may be
// accepted every cycle and a stalled output does not stop the input until all
// three stages are full. The row width is taken from the first row of each
// grid; tlast on the input marks a row end and tuser a grid end, which clears
// the counters after that sample. Registers may be written only while no
// transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_grid_mesher
  import hgm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_we_i,
  input  wire logic [AddrW-1:0] cfg_addr_i,
  input  wire logic [RegW-1:0]  cfg_data_i,
  // samples
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [31:0]      s_axis_tdata,   // [31:0] height_sample
  input  wire logic             s_axis_tlast,   // row_end
  input  wire logic             s_axis_tuser,   // grid_end
  // vertices
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // [47:0] x_position, [95:48] y_position, [143:96] z_position,
  // [167:144] vertex_index, [191:168] first_tri_a, [215:192] first_tri_b,
  // [239:216] first_tri_c, [263:240] second_tri_a, [287:264] second_tri_b,
  // [311:288] second_tri_c
  output logic [311:0]          m_axis_tdata,
  output logic                  m_axis_tuser    // cell_done
);

  hgm_cfg_t    cfg;
  hgm_item_t   item;
  hgm_result_t result;

  logic idx_v_q, prod_v_q, out_v_q;
  logic out_rdy, prod_rdy, idx_rdy, accept;

  assign out_rdy  = !out_v_q || m_axis_tready;
  assign prod_rdy = !prod_v_q || out_rdy;
  assign idx_rdy  = !idx_v_q || prod_rdy;
  assign accept   = s_axis_tvalid && idx_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (idx_rdy) begin
        idx_v_q <= accept;
      end
      if (prod_rdy) begin
        prod_v_q <= idx_v_q;
      end
      if (out_rdy) begin
        out_v_q <= prod_v_q;
      end
    end
  end

  hgm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hgm_index u_index (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .height_i   (s_axis_tdata),
    .row_end_i  (s_axis_tlast),
    .grid_end_i (s_axis_tuser),
    .item_o     (item)
  );

  hgm_arith u_arith (
    .clk_i     (clk_i),
    .cfg_i     (cfg),
    .item_i    (item),
    .prod_en_i (prod_rdy && idx_v_q),
    .sum_en_i  (out_rdy && prod_v_q),
    .result_o  (result)
  );

  assign s_axis_tready = idx_rdy;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = result.cell_done;
  assign m_axis_tdata  = {result.second_tri_c, result.second_tri_b, result.second_tri_a,
                          result.first_tri_c, result.first_tri_b, result.first_tri_a,
                          result.vertex_index, result.z_position, result.y_position,
                          result.x_position};

endmodule

`default_nettype wire
